// File: rtl/phm_pkg.sv
// Shared types and constants for the per-core heat map.
package phm_pkg;

  localparam int NUM_CORES = 8;
  localparam int MAX_ZONES = 8;

  localparam int TEMP_W  = 18;
  localparam int FUNC_W  = 2;
  localparam int IDX_W   = 3;
  localparam int ZCNT_W  = 4;
  localparam int CORE_AW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int ZONE_AW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [TEMP_W-1:0] TEMP_MAX     = '1;
  localparam logic [TEMP_W-1:0] HINT_MARGIN  = 18'd1000;
  localparam logic [TEMP_W-1:0] DECAY_STEP   = 18'd500;
  localparam logic [TEMP_W-1:0] DEGREE_LIMIT = 18'd200;
  localparam logic [TEMP_W-1:0] DEGREE_SCALE = 18'd1000;
  localparam logic [TEMP_W-1:0] THRESH_RESET = 18'd80000;

  localparam int CFG_AW = 1;
  localparam logic [CFG_AW-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_ENABLE    = 1'b1;

  localparam logic [FUNC_W-1:0] FUNC_HINT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DECAY  = 2'd2;

  typedef enum logic [1:0] {
    OP_HINT,
    OP_SAMPLE,
    OP_DECAY,
    OP_NONE
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DECAY,
    ST_REPORT
  } back_state_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  core_index;
    logic [TEMP_W-1:0] zone_reading;
    logic [ZCNT_W-1:0] zone_count;
  } item_t;

  typedef struct packed {
    logic              core_hot;
    logic [TEMP_W-1:0] core_temperature;
  } result_t;

  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  index;
    logic [TEMP_W-1:0] reading;
    logic [ZCNT_W-1:0] zones;
  } cmd_t;

  typedef struct packed {
    logic [TEMP_W-1:0] threshold;
    logic              enable;
  } cfg_t;

endpackage

// File: rtl/phm_front.sv
// Front end: decodes input items, prescales samples, queues commands.
module phm_front import phm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  item_t item,
  output logic  cmd_valid,
  input  logic  cmd_take,
  output cmd_t  cmd
);

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  cmd_t              decoded;
  logic [TEMP_W-1:0] low_deg;
  logic              do_push;
  logic              do_pop;

  always_comb begin
    low_deg = TEMP_W'(item.zone_reading[7:0]);
    decoded.index = item.core_index;
    case (item.func)
      FUNC_HINT:   decoded.op = OP_HINT;
      FUNC_SAMPLE: decoded.op = OP_SAMPLE;
      FUNC_DECAY:  decoded.op = OP_DECAY;
      default:     decoded.op = OP_NONE;
    endcase
    // whole degrees become millicelsius
    if (item.zone_reading < DEGREE_LIMIT) begin
      decoded.reading = low_deg * DEGREE_SCALE;
    end else begin
      decoded.reading = item.zone_reading;
    end
    if (32'(item.zone_count) > MAX_ZONES) begin
      decoded.zones = ZCNT_W'(MAX_ZONES);
    end else begin
      decoded.zones = item.zone_count;
    end
  end

  assign full      = (count == QCNT_W'(QDEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("command queue count out of range");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> wr_ptr == rd_ptr)
    else $error("empty command queue with unequal pointers");

  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_take |=> cmd_valid && $stable(cmd))
    else $error("waiting command changed before transfer");
`endif

endmodule

// File: rtl/phm_back.sv
// Back end: core and zone tables, decay walk, result register.
module phm_back import phm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  input  cmd_t    cmd,
  output logic    cmd_take,
  input  cfg_t    cfg,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  back_state_t        state;
  back_state_t        state_next;
  cmd_t               cur;
  logic [CORE_AW-1:0] cnt;
  logic [TEMP_W-1:0]  est [NUM_CORES];
  logic [TEMP_W-1:0]  zone [MAX_ZONES];
  logic               out_valid;
  result_t            out_q;

  logic [CORE_AW-1:0] rd_core;
  logic [TEMP_W-1:0]  est_rd;
  logic [TEMP_W-1:0]  zone_rd;
  logic               core_ok;
  logic               cnt_last;
  logic [TEMP_W:0]    hint_sum;
  logic [TEMP_W-1:0]  hint_val;
  logic [TEMP_W:0]    avg_sum;
  logic               use_zone;
  logic [TEMP_W-1:0]  mixed;
  logic [TEMP_W-1:0]  decayed;
  result_t            report;

  logic               est_we;
  logic [CORE_AW-1:0] est_wa;
  logic [TEMP_W-1:0]  est_wd;
  logic               zone_we;
  logic               out_load;
  logic               cnt_inc;

  assign rd_core  = (state == ST_DECAY) ? cnt : CORE_AW'(cur.index);
  assign est_rd   = est[rd_core];
  assign zone_rd  = zone[ZONE_AW'(cnt)];
  assign core_ok  = 32'(cur.index) < NUM_CORES;
  assign cnt_last = (cnt == CORE_AW'(NUM_CORES - 1));

  always_comb begin
    hint_sum = {1'b0, cfg.threshold} + {1'b0, HINT_MARGIN};
    hint_val = hint_sum[TEMP_W] ? TEMP_MAX : hint_sum[TEMP_W-1:0];
    // zones is already clamped to the zone table size
    use_zone = 32'(cnt) < 32'(cur.zones);
    avg_sum  = {1'b0, est_rd} + {1'b0, zone_rd};
    mixed    = use_zone ? avg_sum[TEMP_W:1] : est_rd;
    decayed  = (mixed > DECAY_STEP) ? mixed - DECAY_STEP : '0;
    if (core_ok) begin
      report.core_hot         = cfg.enable && (est_rd > cfg.threshold);
      report.core_temperature = est_rd;
    end else begin
      report = '0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = (cmd.op == OP_DECAY) ? ST_DECAY : ST_EXEC;
        end
      end
      ST_EXEC: state_next = ST_REPORT;
      ST_DECAY: begin
        if (cnt_last) begin
          state_next = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (!out_valid || pop) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_take = 1'b0;
    est_we   = 1'b0;
    est_wa   = rd_core;
    est_wd   = hint_val;
    zone_we  = 1'b0;
    out_load = 1'b0;
    cnt_inc  = 1'b0;
    case (state)
      ST_IDLE: cmd_take = cmd_valid;
      ST_EXEC: begin
        case (cur.op)
          OP_HINT:   est_we = cfg.enable && core_ok && (est_rd < cfg.threshold);
          OP_SAMPLE: zone_we = 32'(cur.index) < MAX_ZONES;
          default:   est_we = 1'b0;
        endcase
      end
      ST_DECAY: begin
        est_we  = 1'b1;
        est_wa  = cnt;
        est_wd  = decayed;
        cnt_inc = 1'b1;
      end
      ST_REPORT: out_load = !out_valid || pop;
      default: cmd_take = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (cnt_inc) begin
        cnt <= cnt_last ? '0 : cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cur <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CORES; i++) begin
        est[i] <= '0;
      end
    end else if (est_we) begin
      est[est_wa] <= est_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_ZONES; i++) begin
        zone[i] <= '0;
      end
    end else if (zone_we) begin
      zone[ZONE_AW'(cur.index)] <= cur.reading;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_q <= report;
    end
  end

  assign empty  = !out_valid;
  assign result = out_q;

`ifndef SYNTHESIS
  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    state != ST_DECAY |-> cnt == '0)
    else $error("decay counter not parked outside the walk");

  a_decay_end: assert property (@(posedge clk) disable iff (rst)
    state == ST_DECAY && cnt_last |=> state == ST_REPORT)
    else $error("decay walk did not end after the last core");

  a_report_fill: assert property (@(posedge clk) disable iff (rst)
    state == ST_REPORT && !out_valid |=> out_valid && state == ST_IDLE)
    else $error("free result slot not filled by report");
`endif

endmodule

// File: rtl/per_core_heat_map.sv
// Top level of the per-core heat map: config registers, front end, back end.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------
//   item     | push / full          | item_t: func, core_index,
//            |                      |   zone_reading, zone_count
//   result   | pop / empty          | result_t: core_hot,
//            |                      |   core_temperature
//   config   | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A hint, sample or unused code goes through the back-end states take, execute
// and report; a decay tick walks the core table, one entry per cycle, between take and report.
// The front queue holds two decoded commands, so items are taken while the
// back end works; a result waits in its register until popped.
// Reset clears both tables and the queue and empties the result register;
// threshold resets to 80000 and enable to 1. cfg_ready is always high.
module per_core_heat_map import phm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  item_t             item,
  output logic              empty,
  input  logic              pop,
  output result_t           result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [TEMP_W-1:0] cfg_data
);

  cfg_t cfg;
  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= THRESH_RESET;
      cfg.enable    <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_THRESHOLD: cfg.threshold <= cfg_data;
        CFG_ENABLE:    cfg.enable    <= cfg_data[0];
        default:       cfg.enable    <= cfg.enable;
      endcase
    end
  end

  phm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd)
  );

  phm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .cfg       (cfg),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

// File: dv/per_core_heat_map_tb.sv
// Self-checking testbench for per_core_heat_map: directed and random items, checked against a predictor.
`timescale 1ns / 100ps

module per_core_heat_map_tb;
  import phm_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 204;
  localparam int NUM_PHASES      = 8;
  localparam int STALL_LIMIT     = 4000;
  localparam int SETTLE_CYCLES   = 20;

  // Tracks the heat map state and holds the readouts still owed by the block.
  class heat_map_tracker;
    logic [TEMP_W-1:0] core_est [NUM_CORES];
    logic [TEMP_W-1:0] zone_temp [MAX_ZONES];
    logic [TEMP_W-1:0] threshold;
    logic              enable;
    result_t           expected_readouts [$];
    int                mismatches;

    function new();
      foreach (core_est[c]) core_est[c] = '0;
      foreach (zone_temp[z]) zone_temp[z] = '0;
      threshold  = THRESH_RESET;
      enable     = 1'b1;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_AW-1:0] idx, logic [TEMP_W-1:0] data);
      if (idx == CFG_THRESHOLD) begin
        threshold = data;
      end else if (idx == CFG_ENABLE) begin
        enable = data[0];
      end
    endfunction

    function void log_item(item_t it);
      logic [TEMP_W:0]   sum;
      logic [TEMP_W-1:0] t;
      logic [TEMP_W-1:0] reading;
      int                zones;
      result_t           r;
      case (it.func)
        FUNC_HINT: begin
          if (enable && it.core_index < NUM_CORES &&
              core_est[it.core_index] < threshold) begin
            sum = {1'b0, threshold} + HINT_MARGIN;
            core_est[it.core_index] = (sum > TEMP_MAX) ? TEMP_MAX : sum[TEMP_W-1:0];
          end
        end
        FUNC_SAMPLE: begin
          if (it.core_index < MAX_ZONES) begin
            reading = it.zone_reading;
            if (reading < DEGREE_LIMIT) reading = reading * DEGREE_SCALE;
            zone_temp[it.core_index] = reading;
          end
        end
        FUNC_DECAY: begin
          zones = (it.zone_count > MAX_ZONES) ? MAX_ZONES : int'(it.zone_count);
          for (int c = 0; c < NUM_CORES; c++) begin
            t = core_est[c];
            if (c < zones) begin
              sum = {1'b0, t} + zone_temp[c];
              t = sum[TEMP_W:1];
            end
            // saturating decay: anything at or below the step drops to zero
            t = (t > DECAY_STEP) ? t - DECAY_STEP : '0;
            core_est[c] = t;
          end
        end
        default: ;
      endcase
      if (it.core_index < NUM_CORES) begin
        r.core_temperature = core_est[it.core_index];
        r.core_hot = enable && (core_est[it.core_index] > threshold);
      end else begin
        r = '0;
      end
      expected_readouts.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_readouts.size() == 0) begin
        $error("unexpected result: core_hot %0d core_temperature %0d",
               got.core_hot, got.core_temperature);
        mismatches++;
        return;
      end
      exp = expected_readouts.pop_front();
      if (got.core_hot !== exp.core_hot) begin
        $error("core_hot: expected %0d, actual %0d", exp.core_hot, got.core_hot);
        mismatches++;
      end
      if (got.core_temperature !== exp.core_temperature) begin
        $error("core_temperature: expected %0d, actual %0d",
               exp.core_temperature, got.core_temperature);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_readouts.size();
    endfunction
  endclass

  logic              clk;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  item_t             item = '0;
  logic              empty;
  logic              pop = 1'b0;
  result_t           result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_AW-1:0] cfg_index = '0;
  logic [TEMP_W-1:0] cfg_data = '0;

  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int idle_cycles = 0;

  heat_map_tracker tracker = new();

  per_core_heat_map u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // transfers on both sides, seen at the clock edge
  always @(posedge clk) begin
    if (!rst && push && !full) tracker.log_item(item);
    if (!rst && pop && !empty) tracker.check_result(result);
  end

  always @(posedge clk) begin
    pop <= !rst && ($urandom_range(99) >= pop_stall_pct);
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("per_core_heat_map_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic item_t mk_item(logic [FUNC_W-1:0] func, logic [IDX_W-1:0] idx,
                                    logic [TEMP_W-1:0] reading, logic [ZCNT_W-1:0] zones);
    item_t it;
    it.func         = func;
    it.core_index   = idx;
    it.zone_reading = reading;
    it.zone_count   = zones;
    return it;
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int    r;
    r = $urandom_range(99);
    it.func = (r < 35) ? FUNC_HINT : (r < 65) ? FUNC_SAMPLE :
              (r < 95) ? FUNC_DECAY : FUNC_UNUSED;
    it.core_index = IDX_W'($urandom_range(NUM_CORES - 1));
    case ($urandom_range(3))
      0:       it.zone_reading = TEMP_W'($urandom_range(DEGREE_LIMIT - 1));
      1:       it.zone_reading = TEMP_W'($urandom_range(130000, 20000));
      2:       it.zone_reading = TEMP_W'($urandom);
      default: it.zone_reading = TEMP_W'($urandom_range(TEMP_MAX, 199500));
    endcase
    it.zone_count = ZCNT_W'($urandom_range(1) ? $urandom_range(MAX_ZONES) :
                                                $urandom_range(15));
    return it;
  endfunction

  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
  endtask

  // hold off the sender until every owed readout has been popped
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [TEMP_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [TEMP_W-1:0] thr;
    logic              en;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reading scaling edges, zone count extremes, repeat hints, unused code
    send_item(mk_item(FUNC_HINT,   3'd0, '0,         4'd0));
    send_item(mk_item(FUNC_HINT,   3'd0, TEMP_MAX,   4'd15));
    send_item(mk_item(FUNC_SAMPLE, 3'd0, '0,         4'd0));
    send_item(mk_item(FUNC_SAMPLE, 3'd1, 18'd199,    4'd0));
    send_item(mk_item(FUNC_SAMPLE, 3'd2, 18'd200,    4'd0));
    send_item(mk_item(FUNC_SAMPLE, 3'd7, TEMP_MAX,   4'd15));
    send_item(mk_item(FUNC_SAMPLE, 3'd3, 18'd1,      4'd0));
    send_item(mk_item(FUNC_SAMPLE, 3'd4, 18'd120000, 4'd0));
    send_item(mk_item(FUNC_DECAY,  3'd0, '0,         4'd0));
    send_item(mk_item(FUNC_DECAY,  3'd1, TEMP_MAX,   4'd15));
    send_item(mk_item(FUNC_DECAY,  3'd7, '0,         4'd8));
    send_item(mk_item(FUNC_UNUSED, 3'd7, TEMP_MAX,   4'd15));
    send_item(mk_item(FUNC_HINT,   3'd7, '0,         4'd0));
    send_item(mk_item(FUNC_DECAY,  3'd0, '0,         4'd1));
    send_item(mk_item(FUNC_DECAY,  3'd2, '0,         4'd3));
    send_item(mk_item(FUNC_HINT,   3'd3, '0,         4'd0));
    send_item(mk_item(FUNC_DECAY,  3'd3, '0,         4'd4));
    send_item(mk_item(FUNC_DECAY,  3'd4, '0,         4'd9));
    send_item(mk_item(FUNC_HINT,   3'd4, '0,         4'd0));
    send_item(mk_item(FUNC_UNUSED, 3'd0, '0,         4'd0));
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0:       begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1:       begin send_idle_pct = 81; pop_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  pop_stall_pct = 81; end
        default: begin send_idle_pct = 34; pop_stall_pct = 34; end
      endcase
      case (p)
        0:       thr = THRESH_RESET;
        1:       thr = '0;
        2:       thr = 18'd200000;
        3:       thr = TEMP_W'($urandom_range(200000));
        4:       thr = TEMP_MAX;
        5:       thr = 18'd261500;   // hint target saturates
        6:       thr = TEMP_W'($urandom_range(120000, 40000));
        default: thr = TEMP_W'($urandom_range(TEMP_MAX));
      endcase
      en = (p == 3 || p == 6) ? 1'b0 : 1'b1;
      write_reg(CFG_THRESHOLD, thr);
      write_reg(CFG_ENABLE, {{(TEMP_W-1){1'b0}}, en});
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i == ITEMS_PER_PHASE / 2) drain();
        send_item(rand_item());
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.pending() != 0) $error("%0d expected results never arrived", tracker.pending());
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("per_core_heat_map_tb OK");
    end else begin
      $display("per_core_heat_map_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/phm_pkg.sv
rtl/phm_front.sv
rtl/phm_back.sv
rtl/per_core_heat_map.sv
dv/per_core_heat_map_tb.sv
